// File: src/swup_pkg.sv
package swup_pkg;

  localparam int OP_W     = 3;
  localparam int CAT_W    = 3;
  localparam int NCAT     = 5;
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 16;
  localparam int OUT_W    = 16;
  localparam int BUSY_W   = 7;

  // Sized for windows of up to 16 samples
  localparam int SUM_W = 36;
  localparam int DVD_W = 52;
  localparam int DVS_W = 46;
  localparam int TOT_W = 46;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd250;
  localparam logic [OUT_W-1:0]    SAT16        = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_RESTART  = 3'd0,
    OP_TIME     = 3'd1,
    OP_FRAME    = 3'd2,
    OP_CATEGORY = 3'd3,
    OP_REPORT   = 3'd4
  } op_t;

  localparam logic [CAT_W-1:0] CAT_OTHER = 3'd0;
  localparam logic [CAT_W-1:0] CAT_IDLE  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREDIT,
    S_SHIFT,
    S_SUM,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_BUSY_LOAD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0]                 frames;
    logic [NCAT-1:0][TIME_W-1:0]       times;
  } row_t;

endpackage

// File: src/swup_if.sv
interface swup_item_if import swup_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [TIME_W-1:0] now_ms;
  logic [CAT_W-1:0]  category;

  modport source (output valid, op, now_ms, category, input ready);
  modport sink   (input valid, op, now_ms, category, output ready);
endinterface

interface swup_result_if import swup_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              report_valid;
  logic [OUT_W-1:0]  frames_per_second;
  logic [BUSY_W-1:0] busy_percent;
  logic [OUT_W-1:0]  other_ms_per_s;
  logic [OUT_W-1:0]  graphics_ms_per_s;
  logic [OUT_W-1:0]  io_ms_per_s;
  logic [OUT_W-1:0]  application_ms_per_s;
  logic [OUT_W-1:0]  idle_ms_per_s;

  modport source (output valid, report_valid, frames_per_second, busy_percent,
                  other_ms_per_s, graphics_ms_per_s, io_ms_per_s,
                  application_ms_per_s, idle_ms_per_s, input ready);
  modport sink   (input valid, report_valid, frames_per_second, busy_percent,
                  other_ms_per_s, graphics_ms_per_s, io_ms_per_s,
                  application_ms_per_s, idle_ms_per_s, output ready);
endinterface

// File: src/sliding_window_usage_profiler.sv
// Usage profiler over a sliding window of sample periods.
// item channel: one beat per event (restart, time update, frame seen,
// set category, report) carrying the current millisecond time.
// result channel: exactly one beat per item; only a report on a full window
// carries nonzero figures (fps, per-category ms per second, busy percent).
// cfg_wr_en/cfg_wr_data write the sample period; write only while idle.
// Item ready only in the idle state. A time, frame, category or report
// item passes the credit state, then the window shift state, which makes up
// to WINDOW_SAMPLES+1 window shifts, one per cycle, before the output state;
// a restart or an unknown op goes straight to the output state.
// The next item is taken once the result register is loaded.
// A report on a full window then sums and divides: each of
// the six sums is gathered one sample a cycle, then one shared restoring
// divider produces one quotient bit a cycle over 52 bits, and a seventh
// division gives the busy percent (skipped when all averages are 0).
// Reset clears the window, the counters and the period (250 ms) at once.
// A stalled result beat holds in the output register; the next item is still
// accepted and runs until its own result waits for the register to free.
module sliding_window_usage_profiler import swup_pkg::*; #(
  parameter int WINDOW_SAMPLES = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [PERIOD_W-1:0] cfg_wr_data,
  swup_item_if.sink           item,
  swup_result_if.source       result
);

  localparam int IDX_W    = $clog2(WINDOW_SAMPLES + 1);
  localparam int PASS_W   = $clog2(WINDOW_SAMPLES + 2);
  localparam int WIN_MS_W = PERIOD_W + $clog2(WINDOW_SAMPLES + 1);
  localparam int CNT_W    = $clog2(DVD_W + 1);

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_SAMPLES - 1);
  localparam logic [IDX_W-1:0]  FULL     = IDX_W'(WINDOW_SAMPLES);
  localparam logic [PASS_W-1:0] PASS_MAX = PASS_W'(WINDOW_SAMPLES + 1);
  localparam logic [CNT_W-1:0]  DIV_STEPS = CNT_W'(DVD_W);

  localparam logic [2:0] FLD_FRAMES = 3'd0;
  localparam logic [2:0] FLD_IDLE   = 3'd5;
  localparam logic [2:0] FLD_BUSY   = 3'd6;

  state_t state, state_next;

  logic [PERIOD_W-1:0] sample_period;
  logic [WIN_MS_W-1:0] window_ms;
  row_t                win [WINDOW_SAMPLES+1];
  logic [CAT_W-1:0]    active;
  logic [TIME_W-1:0]   last_mark;
  logic [TIME_W-1:0]   sample_start;
  logic [IDX_W-1:0]    taken;

  logic [OP_W-1:0]     op_q;
  logic [TIME_W-1:0]   now_q;
  logic [CAT_W-1:0]    cat_q;
  logic [PASS_W-1:0]   pass;
  logic [IDX_W-1:0]    sum_idx;
  logic [2:0]          fld;
  logic [SUM_W-1:0]    acc;
  logic [TOT_W-1:0]    avg_total;
  logic [TOT_W-1:0]    avg_nonidle;

  logic [DVS_W:0]      div_rem;
  logic [DVD_W-1:0]    div_quo;
  logic [DVS_W-1:0]    div_den;
  logic [CNT_W-1:0]    div_cnt;

  logic                rep_ok;
  logic [OUT_W-1:0]    fps_r;
  logic [BUSY_W-1:0]   busy_r;
  logic [OUT_W-1:0]    ms_r [NCAT];
  logic                out_valid;

  logic [TIME_W-1:0]   diff_mark;
  logic [TIME_W-1:0]   diff_start;
  logic                behind;
  logic                do_shift;
  logic [TIME_W-1:0]   field_val;
  logic [DVS_W:0]      rem_shift;
  logic                rem_fits;
  logic [DVS_W:0]      rem_next;
  logic [DVD_W-1:0]    quo_next;
  logic [DVD_W-1:0]    acc_ext;
  logic [DVD_W-1:0]    pps_dvd;
  logic [DVS_W-1:0]    pps_den;
  logic [DVD_W-1:0]    nonidle_ext;
  logic [DVD_W-1:0]    busy_dvd;
  logic                out_free;

  function automatic logic [OUT_W-1:0] sat16(input logic [DVD_W-1:0] v);
    return (v > DVD_W'(SAT16)) ? SAT16 : v[OUT_W-1:0];
  endfunction

  assign diff_mark  = now_q - last_mark;
  assign diff_start = now_q - sample_start;
  assign behind     = diff_start >= TIME_W'(sample_period);
  assign do_shift   = behind && (pass < PASS_MAX);

  always_comb begin
    case (fld)
      3'd0:    field_val = win[sum_idx].frames;
      3'd1:    field_val = win[sum_idx].times[0];
      3'd2:    field_val = win[sum_idx].times[1];
      3'd3:    field_val = win[sum_idx].times[2];
      3'd4:    field_val = win[sum_idx].times[3];
      3'd5:    field_val = win[sum_idx].times[4];
      default: field_val = '0;
    endcase
  end

  // Restoring divider step: one quotient bit per cycle
  assign rem_shift = {div_rem[DVS_W-1:0], div_quo[DVD_W-1]};
  assign rem_fits  = rem_shift >= {1'b0, div_den};
  assign rem_next  = rem_fits ? (rem_shift - {1'b0, div_den}) : rem_shift;
  assign quo_next  = {div_quo[DVD_W-2:0], rem_fits};

  // (2000 * sum + d) / (2 * d), d = period * window
  assign acc_ext = DVD_W'(acc);
  assign pps_dvd = (acc_ext << 11) - (acc_ext << 5) - (acc_ext << 4)
                   + DVD_W'(window_ms);
  assign pps_den = DVS_W'({window_ms, 1'b0});

  assign nonidle_ext = DVD_W'(avg_nonidle);
  assign busy_dvd    = (nonidle_ext << 6) + (nonidle_ext << 5) + (nonidle_ext << 2);

  assign out_free   = !out_valid || result.ready;
  assign item.ready = (state == S_IDLE) && !rst;
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item.valid) begin
          case (item.op)
            OP_TIME, OP_FRAME, OP_CATEGORY, OP_REPORT: state_next = S_CREDIT;
            default:                                   state_next = S_OUT;
          endcase
        end
      end
      S_CREDIT: state_next = S_SHIFT;
      S_SHIFT: begin
        if (!do_shift) begin
          if (op_q == OP_REPORT && taken == FULL) state_next = S_SUM;
          else                                    state_next = S_OUT;
        end
      end
      S_SUM: begin
        if (sum_idx == LAST_IDX) state_next = S_DIV_LOAD;
      end
      S_DIV_LOAD: state_next = S_DIV_RUN;
      S_DIV_RUN: begin
        if (div_cnt == CNT_W'(1)) begin
          if (fld == FLD_BUSY)      state_next = S_OUT;
          else if (fld == FLD_IDLE) state_next = S_BUSY_LOAD;
          else                      state_next = S_SUM;
        end
      end
      S_BUSY_LOAD: begin
        if (avg_total == '0) state_next = S_OUT;
        else                 state_next = S_DIV_RUN;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    window_ms <= WIN_MS_W'(sample_period) * WIN_MS_W'(WINDOW_SAMPLES);
    if (rst) begin
      sample_period <= PERIOD_RESET;
      for (int i = 0; i <= WINDOW_SAMPLES; i++) win[i] <= '0;
      active       <= CAT_OTHER;
      last_mark    <= '0;
      sample_start <= '0;
      taken        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sample_period <= (cfg_wr_data == '0) ? PERIOD_W'(1) : cfg_wr_data;
      end
      // The output state reloads the register itself
      if (out_valid && result.ready && state != S_OUT) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (item.valid) begin
            op_q   <= item.op;
            now_q  <= item.now_ms;
            cat_q  <= item.category;
            rep_ok <= 1'b0;
            pass   <= '0;
            if (item.op == OP_RESTART) begin
              for (int i = 0; i <= WINDOW_SAMPLES; i++) win[i] <= '0;
              taken        <= '0;
              sample_start <= '0;
              active       <= CAT_OTHER;
              last_mark    <= item.now_ms;
            end
          end
        end
        S_CREDIT: begin
          win[WINDOW_SAMPLES].times[active] <= win[WINDOW_SAMPLES].times[active] + diff_mark;
        end
        S_SHIFT: begin
          if (do_shift) begin
            // Advance the window by one sample
            for (int i = 0; i < WINDOW_SAMPLES; i++) win[i] <= win[i+1];
            win[WINDOW_SAMPLES] <= '0;
            sample_start <= sample_start + TIME_W'(sample_period);
            if (taken < FULL) taken <= taken + IDX_W'(1);
            pass <= pass + PASS_W'(1);
          end else begin
            // Still behind after the last pass: jump to now
            if (behind) sample_start <= now_q;
            last_mark <= now_q;
            rep_ok    <= (op_q == OP_REPORT) && (taken == FULL);
            fld         <= FLD_FRAMES;
            sum_idx     <= '0;
            acc         <= '0;
            avg_total   <= '0;
            avg_nonidle <= '0;
            case (op_q)
              OP_FRAME: begin
                win[WINDOW_SAMPLES].frames <= win[WINDOW_SAMPLES].frames + TIME_W'(1);
              end
              OP_CATEGORY: begin
                if (cat_q < CAT_W'(NCAT)) active <= cat_q;
              end
              default: ;
            endcase
          end
        end
        S_SUM: begin
          acc <= acc + SUM_W'(field_val);
          if (sum_idx != LAST_IDX) sum_idx <= sum_idx + IDX_W'(1);
        end
        S_DIV_LOAD: begin
          div_rem <= '0;
          div_quo <= pps_dvd;
          div_den <= pps_den;
          div_cnt <= DIV_STEPS;
        end
        S_DIV_RUN: begin
          div_rem <= rem_next;
          div_quo <= quo_next;
          div_cnt <= div_cnt - CNT_W'(1);
          if (div_cnt == CNT_W'(1)) begin
            case (fld)
              FLD_FRAMES: fps_r <= sat16(quo_next);
              FLD_BUSY:   busy_r <= quo_next[BUSY_W-1:0];
              default: begin
                ms_r[3'(fld - 3'd1)] <= sat16(quo_next);
                avg_total <= avg_total + TOT_W'(quo_next);
                if (fld != FLD_IDLE) avg_nonidle <= avg_nonidle + TOT_W'(quo_next);
              end
            endcase
            fld     <= fld + 3'd1;
            sum_idx <= '0;
            acc     <= '0;
          end
        end
        S_BUSY_LOAD: begin
          if (avg_total == '0) begin
            busy_r <= '0;
          end else begin
            div_rem <= '0;
            div_quo <= busy_dvd;
            div_den <= DVS_W'(avg_total);
            div_cnt <= DIV_STEPS;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid                   <= 1'b1;
            result.report_valid         <= rep_ok;
            result.frames_per_second    <= rep_ok ? fps_r : '0;
            result.busy_percent         <= rep_ok ? busy_r : '0;
            result.other_ms_per_s       <= rep_ok ? ms_r[0] : '0;
            result.graphics_ms_per_s    <= rep_ok ? ms_r[1] : '0;
            result.io_ms_per_s          <= rep_ok ? ms_r[2] : '0;
            result.application_ms_per_s <= rep_ok ? ms_r[3] : '0;
            result.idle_ms_per_s        <= rep_ok ? ms_r[4] : '0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_RUN |-> div_rem < {1'b0, div_den})
    else $error("divider remainder not below divisor");

  a_busy_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_RUN && div_cnt == CNT_W'(1) && fld == FLD_BUSY)
      |-> quo_next <= DVD_W'(100))
    else $error("busy percent above 100");

  a_pass_bounded: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> pass <= PASS_MAX)
    else $error("window shifted too often");

  a_active_legal: assert property (@(posedge clk) disable iff (rst)
    active < CAT_W'(NCAT))
    else $error("active category out of range");

  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result beat raised outside output state");
`endif

endmodule
